// ===== src/lbachs_pkg.sv =====
// Package for the LBA-to-CHS read splitter: request/result structs,
// divider interface structs, sequencer states and register indexes.
// No dependencies.
package lbachs_pkg;

   // Geometry and request limits
   localparam int GROUP_SECTORS = 4;
   localparam int MAX_REQUEST   = 64;
   localparam int LBA_W         = 32;
   localparam int DIVISOR_W     = 9;
   localparam int DIV_CNT_W     = $clog2(LBA_W);

   // Configuration register indexes (paddr bit 2)
   localparam logic REG_SECTORS_PER_TRACK  = 1'b0;
   localparam logic REG_HEADS_PER_CYLINDER = 1'b1;

   // Request payload
   typedef struct packed {
      logic [7:0]       drive_number;
      logic [LBA_W-1:0] start_lba;
      logic [6:0]       sector_count;
   } req_type;

   // Result payload, one per chunk
   typedef struct packed {
      logic [7:0]  drive_out;
      logic [15:0] cylinder;
      logic [7:0]  head_number;
      logic [5:0]  sector_number;
      logic [4:0]  chunk_length;
      logic [5:0]  request_offset;
      logic        last_chunk;
   } rsp_type;

   // Shared divider command and status
   typedef struct packed {
      logic                 start;
      logic [LBA_W-1:0]     dividend;
      logic [DIVISOR_W-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic                 done;
      logic [LBA_W-1:0]     quotient;
      logic [DIVISOR_W-1:0] remainder;
   } div_rsp_type;

   // Chunk sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TRK_GO,
      ST_TRK_WAIT,
      ST_CYL_GO,
      ST_CYL_WAIT,
      ST_EMIT
   } seq_state_type;

endpackage

// ===== src/lba_to_chs_read_splitter.sv =====
// Top level of the LBA-to-CHS read splitter: geometry registers on the
// APB-style port, chunk sequencer and shared divider. Depends on lbachs_pkg,
// lbachs_div and lbachs_seq.
//
// Usage:
//  - req_* carries one read request (drive, start LBA, sector count); it is
//    taken when req_valid is high and req_stall low. Counts above 64 are
//    treated as 64; a count of 0 is taken and gives no result.
//  - rsp_* carries one result per chunk: CHS address of the chunk start,
//    length (at most 4, never across a track end), offset within the
//    request and a last flag. Results are taken when rsp_valid is high and
//    rsp_stall low.
//  - Each chunk takes two passes through the one bit-per-cycle divider
//    (LBA by sectors per track, then track by heads) plus start, wait
//    and load states; req_stall stays high until the last chunk is loaded.
//  - The result register frees the sequencer: the next chunk's divisions
//    run while a result waits, and a new request may be taken while the
//    last result of the previous one still waits. A held rsp_stall stops
//    the sequencer only at the point of loading the next result.
//  - Reset (synchronous) returns to idle with no pending result and sets
//    63 sectors per track and 16 heads. Write geometry only while idle.
module lba_to_chs_read_splitter (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  lbachs_pkg::req_type   req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output lbachs_pkg::rsp_type   rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [2:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   logic [5:0]                spt_ff, spt_in;
   logic [8:0]                hpc_ff, hpc_in;
   logic [5:0]                spt_eff;
   logic [8:0]                hpc_eff;
   logic                      csr_write;
   lbachs_pkg::div_cmd_type   div_cmd;
   lbachs_pkg::div_rsp_type   div_rsp;

   // Register writes and reads
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      spt_in = spt_ff;
      hpc_in = hpc_ff;
      if (csr_write) begin
         case (paddr[2])
            lbachs_pkg::REG_SECTORS_PER_TRACK:  spt_in = pwdata[5:0];
            lbachs_pkg::REG_HEADS_PER_CYLINDER: hpc_in = pwdata[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         lbachs_pkg::REG_SECTORS_PER_TRACK:  prdata = {26'd0, spt_ff};
         lbachs_pkg::REG_HEADS_PER_CYLINDER: prdata = {23'd0, hpc_ff};
         default:                            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spt_ff <= 6'd63;
         hpc_ff <= 9'd16;
      end else begin
         spt_ff <= spt_in;
         hpc_ff <= hpc_in;
      end
   end

   // Zero geometry is used as one; heads saturate at 256
   always_comb begin
      spt_eff = (spt_ff == '0) ? 6'd1 : spt_ff;
      if (hpc_ff == '0) begin
         hpc_eff = 9'd1;
      end else if (hpc_ff > 9'd256) begin
         hpc_eff = 9'd256;
      end else begin
         hpc_eff = hpc_ff;
      end
   end

   lbachs_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .spt       (spt_eff),
      .hpc       (hpc_eff),
      .div_cmd   (div_cmd),
      .div_rsp   (div_rsp)
   );

   lbachs_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_cmd (div_cmd),
      .div_rsp (div_rsp)
   );

   // Chunk length stays within one group and is never empty
   a_chunk_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.chunk_length != '0) &&
                    (rsp_data.chunk_length <= 5'(lbachs_pkg::GROUP_SECTORS)))
      else $error("chunk length out of range");

   // Sector number is one-based and inside the track
   a_sector_num: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.sector_number != '0) &&
                    (rsp_data.sector_number <= spt_eff))
      else $error("sector number outside the track");

   // A chunk never runs past the largest request
   a_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (7'(rsp_data.request_offset) + 7'(rsp_data.chunk_length)
                     <= 7'(lbachs_pkg::MAX_REQUEST)))
      else $error("chunk runs past the request");

   // The divider start is never asserted twice in a row
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_cmd.start |=> !div_cmd.start)
      else $error("divider started twice in a row");

endmodule

// ===== src/lbachs_div.sv =====
// Shared restoring divider: 32-bit dividend by a 9-bit divisor (1..256),
// one quotient bit per cycle. Depends on lbachs_pkg.
module lbachs_div (
   input  logic                      clock,
   input  logic                      reset,
   input  lbachs_pkg::div_cmd_type   div_cmd,
   output lbachs_pkg::div_rsp_type   div_rsp
);

   logic                                 busy_ff, busy_in;
   logic                                 done_ff, done_in;
   logic [lbachs_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [lbachs_pkg::LBA_W-1:0]         quo_ff, quo_in;
   logic [lbachs_pkg::DIVISOR_W-1:0]     rem_ff, rem_in;
   logic [lbachs_pkg::DIVISOR_W-1:0]     divisor_ff, divisor_in;
   logic [lbachs_pkg::DIVISOR_W-1:0]     trial;
   logic                                 fits;

   // One restoring step: remainder stays below the divisor (<= 255)
   always_comb begin
      trial = {rem_ff[lbachs_pkg::DIVISOR_W-2:0], quo_ff[lbachs_pkg::LBA_W-1]};
      fits  = (trial >= divisor_ff);
   end

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (div_cmd.start) begin
         busy_in    = 1'b1;
         cnt_in     = '0;
         quo_in     = div_cmd.dividend;
         rem_in     = '0;
         divisor_in = div_cmd.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[lbachs_pkg::LBA_W-2:0], fits};
         rem_in = fits ? (trial - divisor_ff) : trial;
         cnt_in = cnt_ff + lbachs_pkg::DIV_CNT_W'(1);
         if (cnt_ff == lbachs_pkg::DIV_CNT_W'(lbachs_pkg::LBA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

// ===== src/lbachs_seq.sv =====
// Chunk sequencer: holds the running request, drives the shared divider
// twice per chunk and loads the result register. Depends on lbachs_pkg.
module lbachs_seq (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  lbachs_pkg::req_type       req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output lbachs_pkg::rsp_type       rsp_data,
   input  logic [5:0]                spt,
   input  logic [8:0]                hpc,
   output lbachs_pkg::div_cmd_type   div_cmd,
   input  lbachs_pkg::div_rsp_type   div_rsp
);

   lbachs_pkg::seq_state_type   state_ff, state_in;

   logic [lbachs_pkg::LBA_W-1:0] lba_ff, lba_in;
   logic [6:0]                   remaining_ff, remaining_in;
   logic [4:0]                   group_ff, group_in;
   logic [5:0]                   covered_ff, covered_in;
   logic [7:0]                   drive_ff, drive_in;
   logic [5:0]                   in_track_ff, in_track_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   lbachs_pkg::rsp_type          rsp_ff, rsp_in;

   logic [6:0]                   count_sat;
   logic                         req_take;
   logic                         out_free;
   logic                         emit_load;
   logic [4:0]                   group_eff;
   logic [5:0]                   room;
   logic [4:0]                   len;
   logic                         last;

   // Request count, saturated to the largest request
   always_comb begin
      count_sat = (req_data.sector_count > 7'(lbachs_pkg::MAX_REQUEST)) ?
                  7'(lbachs_pkg::MAX_REQUEST) : req_data.sector_count;
      req_take  = req_valid && (state_ff == lbachs_pkg::ST_IDLE);
      out_free  = !rsp_valid_ff || !rsp_stall;
   end

   // Chunk length: bounded by the open group and by the end of the track
   always_comb begin
      if (group_ff == '0) begin
         group_eff = (remaining_ff < 7'(lbachs_pkg::GROUP_SECTORS)) ?
                     remaining_ff[4:0] : 5'(lbachs_pkg::GROUP_SECTORS);
      end else begin
         group_eff = group_ff;
      end
      room = spt - in_track_ff;
      len  = (6'(group_eff) < room) ? group_eff : room[4:0];
      last = (remaining_ff == 7'(len));
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lbachs_pkg::ST_IDLE: begin
            if (req_valid && (count_sat != '0)) state_in = lbachs_pkg::ST_TRK_GO;
         end
         lbachs_pkg::ST_TRK_GO:   state_in = lbachs_pkg::ST_TRK_WAIT;
         lbachs_pkg::ST_TRK_WAIT: begin
            if (div_rsp.done) state_in = lbachs_pkg::ST_CYL_GO;
         end
         lbachs_pkg::ST_CYL_GO:   state_in = lbachs_pkg::ST_CYL_WAIT;
         lbachs_pkg::ST_CYL_WAIT: begin
            if (div_rsp.done) state_in = lbachs_pkg::ST_EMIT;
         end
         lbachs_pkg::ST_EMIT: begin
            if (out_free) state_in = last ? lbachs_pkg::ST_IDLE : lbachs_pkg::ST_TRK_GO;
         end
         default: state_in = lbachs_pkg::ST_IDLE;
      endcase
   end

   // State-decoded outputs: divider commands, input stall, result load
   always_comb begin
      req_stall        = (state_ff != lbachs_pkg::ST_IDLE);
      div_cmd.start    = 1'b0;
      div_cmd.dividend = lba_ff;
      div_cmd.divisor  = {3'b000, spt};
      emit_load        = 1'b0;
      case (state_ff)
         lbachs_pkg::ST_TRK_GO: begin
            div_cmd.start = 1'b1;
         end
         lbachs_pkg::ST_CYL_GO: begin
            div_cmd.start    = 1'b1;
            div_cmd.dividend = div_rsp.quotient;
            div_cmd.divisor  = hpc;
         end
         lbachs_pkg::ST_EMIT: begin
            emit_load = out_free;
         end
         default: ;
      endcase
   end

   // Running request state and result register
   always_comb begin
      lba_in       = lba_ff;
      remaining_in = remaining_ff;
      group_in     = group_ff;
      covered_in   = covered_ff;
      drive_in     = drive_ff;
      in_track_in  = in_track_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (req_take) begin
         lba_in       = req_data.start_lba;
         remaining_in = count_sat;
         group_in     = '0;
         covered_in   = '0;
         drive_in     = req_data.drive_number;
      end

      // track remainder is the sector within the track
      if ((state_ff == lbachs_pkg::ST_TRK_WAIT) && div_rsp.done) begin
         in_track_in = div_rsp.remainder[5:0];
      end

      if (emit_load) begin
         rsp_in.drive_out      = drive_ff;
         rsp_in.cylinder       = div_rsp.quotient[15:0];
         rsp_in.head_number    = div_rsp.remainder[7:0];
         rsp_in.sector_number  = in_track_ff + 6'd1;
         rsp_in.chunk_length   = len;
         rsp_in.request_offset = covered_ff;
         rsp_in.last_chunk     = last;
         rsp_valid_in          = 1'b1;
         lba_in                = lba_ff + lbachs_pkg::LBA_W'(len);
         remaining_in          = remaining_ff - 7'(len);
         group_in              = group_eff - len;
         covered_in            = covered_ff + 6'(len);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lbachs_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         remaining_ff <= '0;
         group_ff     <= '0;
         covered_ff   <= '0;
         lba_ff       <= '0;
         drive_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         remaining_ff <= remaining_in;
         group_ff     <= group_in;
         covered_ff   <= covered_in;
         lba_ff       <= lba_in;
         drive_ff     <= drive_in;
      end
   end

   always_ff @(posedge clock) begin
      in_track_ff <= in_track_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
